// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that carry assertions.
// Standalone header; needs no package and no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sces_pkg.sv -----
// Shared types, scancode and character constants, and keymap lookup
// functions for the scancode to escape sequence unit. No dependencies.
`default_nettype none

package sces_pkg;

  localparam int SEQ_MAX = 8;
  localparam int SEQ_IDX_W = 3;
  localparam int SEQ_CNT_W = 4;

  typedef logic [7:0] byte_t;

  // Modifier bit positions.
  localparam int MOD_CTRL  = 0;
  localparam int MOD_SHIFT = 1;
  localparam int MOD_ALT   = 2;
  localparam int MOD_META  = 3;

  // LED bit positions.
  localparam int SCROLL_LOCK_BIT = 0;
  localparam int NUM_LOCK_BIT    = 1;
  localparam int CAPS_LOCK_BIT   = 2;

  // Result kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LED  = 1'b1;

  localparam int BREAK_BIT = 7;

  // Raw bytes.
  localparam byte_t SC_NULL   = 8'h00;
  localparam byte_t SC_ACK    = 8'hFA;
  localparam byte_t SC_RESEND = 8'hFE;
  localparam byte_t SC_CAPS   = 8'h3A;
  localparam byte_t SC_NUM    = 8'h45;
  localparam byte_t SC_SCROLL = 8'h46;

  // Key codes with the break bit stripped.
  localparam logic [6:0] SC_CTRL     = 7'h1D;
  localparam logic [6:0] SC_LSHIFT   = 7'h2A;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_ALT      = 7'h38;
  localparam logic [6:0] SC_ALTGR    = 7'h60;
  localparam logic [6:0] SC_LMETA    = 7'h5B;
  localparam logic [6:0] SC_RMETA    = 7'h5C;
  localparam logic [6:0] SC_KP_MINUS = 7'h4A;
  localparam logic [6:0] SC_KP_PLUS  = 7'h4E;
  localparam logic [6:0] SC_KP_FIVE  = 7'h4C;

  // Characters used in sequences.
  localparam byte_t CH_ESC    = 8'h1B;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_ONE    = 8'h31;
  localparam byte_t CH_LBRACK = 8'h5B;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_UPPERO = 8'h4F;
  localparam byte_t CH_MINUS  = 8'h2D;
  localparam byte_t CH_PLUS   = 8'h2B;
  localparam byte_t CH_FIVE   = 8'h35;
  localparam byte_t CH_LOWA   = 8'h61;
  localparam byte_t CH_LOWZ   = 8'h7A;

  typedef struct packed {
    logic [3:0] mods;
    logic [2:0] leds;
  } state_t;

  // One decoded scancode: up to eight bytes, or one LED update.
  typedef struct packed {
    logic                     kind;
    logic [2:0]               leds;
    logic [SEQ_CNT_W-1:0]     count;
    byte_t [SEQ_MAX-1:0]      bytes;
  } seq_t;

  // Navigation and function key entry.
  typedef struct packed {
    logic       hit;
    logic       has_short;
    logic       short_o;
    byte_t      short_s;
    logic [1:0] x_tens;
    logic [3:0] x_ones;
    byte_t      fin;
  } nav_t;

  function automatic byte_t key_glyph(input logic [5:0] idx, input logic shifted);
    byte_t lo;
    byte_t up;
    lo = '0;
    up = '0;
    case (idx)
      6'd1:  {lo, up} = {8'h1B, 8'h1B};
      6'd2:  {lo, up} = {"1", "!"};
      6'd3:  {lo, up} = {"2", "@"};
      6'd4:  {lo, up} = {"3", "#"};
      6'd5:  {lo, up} = {"4", "$"};
      6'd6:  {lo, up} = {"5", "%"};
      6'd7:  {lo, up} = {"6", "^"};
      6'd8:  {lo, up} = {"7", "&"};
      6'd9:  {lo, up} = {"8", "*"};
      6'd10: {lo, up} = {"9", "("};
      6'd11: {lo, up} = {"0", ")"};
      6'd12: {lo, up} = {"-", "_"};
      6'd13: {lo, up} = {"=", "+"};
      6'd14: {lo, up} = {8'h08, 8'h08};
      6'd15: {lo, up} = {8'h09, 8'h09};
      6'd16: {lo, up} = {"q", "Q"};
      6'd17: {lo, up} = {"w", "W"};
      6'd18: {lo, up} = {"e", "E"};
      6'd19: {lo, up} = {"r", "R"};
      6'd20: {lo, up} = {"t", "T"};
      6'd21: {lo, up} = {"y", "Y"};
      6'd22: {lo, up} = {"u", "U"};
      6'd23: {lo, up} = {"i", "I"};
      6'd24: {lo, up} = {"o", "O"};
      6'd25: {lo, up} = {"p", "P"};
      6'd26: {lo, up} = {"[", "{"};
      6'd27: {lo, up} = {"]", "}"};
      6'd28: {lo, up} = {8'h0A, 8'h0A};
      6'd30: {lo, up} = {"a", "A"};
      6'd31: {lo, up} = {"s", "S"};
      6'd32: {lo, up} = {"d", "D"};
      6'd33: {lo, up} = {"f", "F"};
      6'd34: {lo, up} = {"g", "G"};
      6'd35: {lo, up} = {"h", "H"};
      6'd36: {lo, up} = {"j", "J"};
      6'd37: {lo, up} = {"k", "K"};
      6'd38: {lo, up} = {"l", "L"};
      6'd39: {lo, up} = {";", ":"};
      6'd40: {lo, up} = {8'h27, 8'h22};
      6'd41: {lo, up} = {8'h60, 8'h7E};
      6'd43: {lo, up} = {8'h5C, 8'h7C};
      6'd44: {lo, up} = {"z", "Z"};
      6'd45: {lo, up} = {"x", "X"};
      6'd46: {lo, up} = {"c", "C"};
      6'd47: {lo, up} = {"v", "V"};
      6'd48: {lo, up} = {"b", "B"};
      6'd49: {lo, up} = {"n", "N"};
      6'd50: {lo, up} = {"m", "M"};
      6'd51: {lo, up} = {",", "<"};
      6'd52: {lo, up} = {".", ">"};
      6'd53: {lo, up} = {"/", "?"};
      6'd57: {lo, up} = {8'h20, 8'h20};
      default: {lo, up} = 16'h0000;
    endcase
    return shifted ? up : lo;
  endfunction

  function automatic nav_t nav_lookup(input logic [6:0] code);
    nav_t r;
    r = '0;
    case (code)
      7'h48: r = '{1'b1, 1'b1, 1'b0, "A", 2'd0, 4'd1, "A"};
      7'h50: r = '{1'b1, 1'b1, 1'b0, "B", 2'd0, 4'd1, "B"};
      7'h4D: r = '{1'b1, 1'b1, 1'b0, "C", 2'd0, 4'd1, "C"};
      7'h4B: r = '{1'b1, 1'b1, 1'b0, "D", 2'd0, 4'd1, "D"};
      7'h47: r = '{1'b1, 1'b1, 1'b0, "H", 2'd0, 4'd1, "H"};
      7'h4F: r = '{1'b1, 1'b1, 1'b0, "F", 2'd0, 4'd1, "F"};
      7'h49: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd0, 4'd5, "~"};
      7'h51: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd0, 4'd6, "~"};
      7'h52: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd0, 4'd2, "~"};
      7'h53: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd0, 4'd3, "~"};
      7'h3B: r = '{1'b1, 1'b1, 1'b1, "P", 2'd1, 4'd1, "~"};
      7'h3C: r = '{1'b1, 1'b1, 1'b1, "Q", 2'd1, 4'd2, "~"};
      7'h3D: r = '{1'b1, 1'b1, 1'b1, "R", 2'd1, 4'd3, "~"};
      7'h3E: r = '{1'b1, 1'b1, 1'b1, "S", 2'd1, 4'd4, "~"};
      7'h3F: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd1, 4'd5, "~"};
      7'h40: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd1, 4'd7, "~"};
      7'h41: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd1, 4'd8, "~"};
      7'h42: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd1, 4'd9, "~"};
      7'h43: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd2, 4'd0, "~"};
      7'h44: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd2, 4'd1, "~"};
      7'h57: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd2, 4'd3, "~"};
      7'h58: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd2, 4'd4, "~"};
      7'h37: r = '{1'b1, 1'b0, 1'b0, 8'h00, 2'd2, 4'd5, "~"};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sces_state_ram.sv -----
// Single-entry synchronous state memory with registered read data.
// Uses sces_pkg for the state word type.
`default_nettype none

module sces_state_ram (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            we,
  input  wire sces_pkg::state_t wdata,
  output sces_pkg::state_t     rdata
);

  sces_pkg::state_t mem [1];
  sces_pkg::state_t q;
  logic             written;
  logic             rd_written;

  // Read-first: a read in the cycle of a write returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
    q <= mem[0];
  end

  // The entry reads as zero until first written after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= 1'b0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written <= 1'b1;
      end
      rd_written <= written;
    end
  end

  assign rdata = rd_written ? q : '0;

endmodule

`default_nettype wire

// ----- rtl/sces_decode.sv -----
// Decodes one scancode against the current modifier and LED state into
// the next state and a byte sequence. Uses sces_pkg tables and types.
`default_nettype none

module sces_decode (
  input  wire logic [7:0]      scancode,
  input  wire sces_pkg::state_t cur,
  output sces_pkg::state_t     nxt,
  output sces_pkg::seq_t       seq
);

  logic                 brk;
  logic [6:0]           code;
  logic [3:0]           mod_bit;
  sces_pkg::byte_t      lo_glyph;
  sces_pkg::byte_t      glyph;
  logic                 alpha;
  sces_pkg::nav_t       nav;
  logic [4:0]           xmod;
  logic [3:0]           xmod_ones;
  logic [3:0]           pos;

  assign brk  = scancode[sces_pkg::BREAK_BIT];
  assign code = scancode[6:0];
  assign nav  = sces_pkg::nav_lookup(code);

  assign lo_glyph = sces_pkg::key_glyph(code[5:0], 1'b0);
  assign alpha    = (lo_glyph >= sces_pkg::CH_LOWA) && (lo_glyph <= sces_pkg::CH_LOWZ);
  assign glyph    = sces_pkg::key_glyph(code[5:0],
                      cur.mods[sces_pkg::MOD_SHIFT] ||
                      (cur.leds[sces_pkg::CAPS_LOCK_BIT] && alpha));

  // xterm modifier number: 1 + shift + 2*alt + 4*ctrl + 8*meta.
  assign xmod = 5'd1 + {4'd0, cur.mods[sces_pkg::MOD_SHIFT]}
                     + {3'd0, cur.mods[sces_pkg::MOD_ALT], 1'b0}
                     + {2'd0, cur.mods[sces_pkg::MOD_CTRL], 2'b0}
                     + {1'd0, cur.mods[sces_pkg::MOD_META], 3'b0};
  assign xmod_ones = (xmod >= 5'd10) ? 4'(xmod - 5'd10) : xmod[3:0];

  always_comb begin
    mod_bit = '0;
    if (code == sces_pkg::SC_CTRL) begin
      mod_bit[sces_pkg::MOD_CTRL] = 1'b1;
    end
    if (code inside {sces_pkg::SC_LSHIFT, sces_pkg::SC_RSHIFT}) begin
      mod_bit[sces_pkg::MOD_SHIFT] = 1'b1;
    end
    if (code inside {sces_pkg::SC_ALT, sces_pkg::SC_ALTGR}) begin
      mod_bit[sces_pkg::MOD_ALT] = 1'b1;
    end
    if (code inside {sces_pkg::SC_LMETA, sces_pkg::SC_RMETA}) begin
      mod_bit[sces_pkg::MOD_META] = 1'b1;
    end
  end

  always_comb begin
    nxt      = cur;
    seq      = '0;
    seq.kind = sces_pkg::KIND_CHAR;
    seq.leds = cur.leds;
    pos      = '0;
    if (scancode inside {sces_pkg::SC_NULL, sces_pkg::SC_ACK, sces_pkg::SC_RESEND}) begin
      seq.count = '0;
    end else if (scancode == sces_pkg::SC_CAPS) begin
      nxt.leds[sces_pkg::CAPS_LOCK_BIT] = ~cur.leds[sces_pkg::CAPS_LOCK_BIT];
      seq.kind  = sces_pkg::KIND_LED;
      seq.leds  = nxt.leds;
      seq.count = 4'd1;
    end else if (scancode == sces_pkg::SC_NUM) begin
      nxt.leds[sces_pkg::NUM_LOCK_BIT] = ~cur.leds[sces_pkg::NUM_LOCK_BIT];
      seq.kind  = sces_pkg::KIND_LED;
      seq.leds  = nxt.leds;
      seq.count = 4'd1;
    end else if (scancode == sces_pkg::SC_SCROLL) begin
      nxt.leds[sces_pkg::SCROLL_LOCK_BIT] = ~cur.leds[sces_pkg::SCROLL_LOCK_BIT];
      seq.kind  = sces_pkg::KIND_LED;
      seq.leds  = nxt.leds;
      seq.count = 4'd1;
    end else if (mod_bit != '0) begin
      nxt.mods = brk ? (cur.mods & ~mod_bit) : (cur.mods | mod_bit);
    end else if (brk) begin
      seq.count = '0;
    end else if (!code[6] && glyph != '0) begin
      seq.bytes[0] = glyph;
      seq.count    = 4'd1;
    end else if (cur.mods == '0 && nav.has_short) begin
      seq.bytes[0] = sces_pkg::CH_ESC;
      seq.bytes[1] = nav.short_o ? sces_pkg::CH_UPPERO : sces_pkg::CH_LBRACK;
      seq.bytes[2] = nav.short_s;
      seq.count    = 4'd3;
    end else if (nav.hit) begin
      seq.bytes[0] = sces_pkg::CH_ESC;
      seq.bytes[1] = sces_pkg::CH_LBRACK;
      pos = 4'd2;
      if (nav.x_tens != '0) begin
        seq.bytes[pos[2:0]] = sces_pkg::CH_ZERO | {6'd0, nav.x_tens};
        pos = pos + 4'd1;
      end
      seq.bytes[pos[2:0]] = sces_pkg::CH_ZERO | {4'd0, nav.x_ones};
      pos = pos + 4'd1;
      if (xmod != 5'd1) begin
        seq.bytes[pos[2:0]] = sces_pkg::CH_SEMI;
        pos = pos + 4'd1;
        if (xmod >= 5'd10) begin
          seq.bytes[pos[2:0]] = sces_pkg::CH_ONE;
          pos = pos + 4'd1;
        end
        seq.bytes[pos[2:0]] = sces_pkg::CH_ZERO | {4'd0, xmod_ones};
        pos = pos + 4'd1;
      end
      seq.bytes[pos[2:0]] = nav.fin;
      pos = pos + 4'd1;
      seq.count = pos;
    end else if (code == sces_pkg::SC_KP_MINUS) begin
      seq.bytes[0] = sces_pkg::CH_MINUS;
      seq.count    = 4'd1;
    end else if (code == sces_pkg::SC_KP_PLUS) begin
      seq.bytes[0] = sces_pkg::CH_PLUS;
      seq.count    = 4'd1;
    end else if (code == sces_pkg::SC_KP_FIVE) begin
      seq.bytes[0] = sces_pkg::CH_FIVE;
      seq.count    = 4'd1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sces_serializer.sv -----
// Holds one decoded sequence and hands it out one word per cycle while res_ready is high.
// Uses sces_pkg for the sequence type and sizes.
`default_nettype none

module sces_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire sces_pkg::seq_t  seq_in,
  output logic                 load_ok,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output logic                 kind,
  output logic [7:0]           char_byte,
  output logic [2:0]           led_bits,
  output logic                 last
);

  sces_pkg::seq_t                     held;
  logic                               busy;
  logic [sces_pkg::SEQ_IDX_W-1:0]     idx;
  logic                               last_now;

  assign last_now = (sces_pkg::SEQ_CNT_W'(idx) + 1'b1) == held.count;

  // A new sequence may load while the final word of the current one leaves.
  assign load_ok = !busy || (res_ready && last_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && res_ready) begin
      if (last_now) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= seq_in;
    end
  end

  assign res_valid = busy;
  assign kind      = held.kind;
  assign char_byte = held.bytes[idx];
  assign led_bits  = held.leds;
  assign last      = last_now;

endmodule

`default_nettype wire

// ----- rtl/scancode_to_escape_sequence_unit.sv -----
// Set-1 scancode to terminal escape sequence converter (top level).
// The first word of a scancode is offered by the serializer register once the decode stage hands it over.
// A new scancode is taken while the result serializer still hands out the words (0 to 8) of
// the last one, one word per cycle while res_ready is high; the state memory is read every cycle
// and written as each scancode retires.
// Reset (rst, synchronous): modifiers and LEDs read as zero, pipeline and serializer empty.
// Depends on sces_pkg, sces_state_ram, sces_decode, sces_serializer and assert_macros.svh.
`default_nettype none

module scancode_to_escape_sequence_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        key_valid,
  output logic             key_ready,
  input  wire logic [7:0]  scancode,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             kind,
  output logic [7:0]       char_byte,
  output logic [2:0]       led_bits,
  output logic             last
);

  `include "assert_macros.svh"

  // Stage 1 holds the accepted scancode while the state word is read.
  logic              s1_valid;
  logic [7:0]        s1_code;
  logic              s1_fire;
  logic              key_acc;

  // State memory and the bypass of the word written on the previous edge.
  sces_pkg::state_t  ram_rdata;
  sces_pkg::state_t  cur_state;
  sces_pkg::state_t  nxt_state;
  logic              state_we;
  logic              fwd_valid;
  sces_pkg::state_t  fwd_state;

  sces_pkg::seq_t    seq;
  logic              ser_load;
  logic              ser_load_ok;

  assign key_acc = key_valid && key_ready;

  // The memory is read every cycle, so its output always reflects every
  // write but one made on the last edge; that one comes from the bypass register.
  // This keeps back-to-back scancodes (and a stalled one) on current state.
  sces_state_ram u_state_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (state_we),
    .wdata (nxt_state),
    .rdata (ram_rdata)
  );

  assign cur_state = fwd_valid ? fwd_state : ram_rdata;

  sces_decode u_decode (
    .scancode (s1_code),
    .cur      (cur_state),
    .nxt      (nxt_state),
    .seq      (seq)
  );

  // A scancode with no words retires at once; one with words waits until
  // the serializer can take its sequence. State is written as it retires.
  assign s1_fire   = s1_valid && ((seq.count == '0) || ser_load_ok);
  assign state_we  = s1_fire;
  assign ser_load  = s1_fire && (seq.count != '0);
  assign key_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (key_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      fwd_valid <= state_we;
    end
  end

  always_ff @(posedge clk) begin
    if (key_acc) begin
      s1_code <= scancode;
    end
    fwd_state <= nxt_state;
  end

  // The serializer register parts the result side from the decode side,
  // so a new scancode is taken while a word waits to be accepted.
  sces_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (ser_load),
    .seq_in    (seq),
    .load_ok   (ser_load_ok),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .kind      (kind),
    .char_byte (char_byte),
    .led_bits  (led_bits),
    .last      (last)
  );

  // An LED update is always a single word with a zero character.
  `ASSERT_IMPLIES(a_led_single, clk, rst, res_valid && (kind == sces_pkg::KIND_LED), last && (char_byte == 8'h00), "LED word is not a lone zero-character word")
  // A sequence is delivered without gaps once it has started.
  `ASSERT_NEXT(a_seq_no_gap, clk, rst, res_valid && !last, res_valid, "result sequence broke off before its last word")
  // An accepted scancode always lands in the decode stage.
  `ASSERT_NEXT(a_key_lands, clk, rst, key_acc, s1_valid, "accepted scancode was lost")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for scancode_to_escape_sequence_unit: a clocked driver and
// monitor around the block, checked against a predictor of the scancode translation.
// Depends on sces_pkg and on the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;

  // Least number of scancodes sent, filler bytes and the directed opening included.
  localparam int KEY_COUNT = 480;
  // The run stops here whatever happens; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to watch for stray words once every expected word has arrived.
  localparam int SETTLE_CYCLES = 30;
  // Receiver hold-off: starts after this many scancodes, lasts this many cycles.
  localparam int HOLD_AFTER = 100;
  localparam int HOLD_CYCLES = 400;
  // Window of accepted scancodes in which neither side idles.
  localparam int CALM_FROM = 200;
  localparam int CALM_TO = 320;
  // The sender waits for the block to drain before the first scancode queued from this count on.
  localparam int DRAIN_AT = 380;
  localparam int IDLE_PERCENT = 38;

  localparam sces_pkg::byte_t BRK_FLAG    = 8'h80;
  localparam sces_pkg::byte_t KEY_ONE     = 8'h02;
  localparam sces_pkg::byte_t KEY_A       = 8'h1E;
  localparam sces_pkg::byte_t KEY_F1      = 8'h3B;
  localparam sces_pkg::byte_t KEY_F12     = 8'h58;
  localparam sces_pkg::byte_t KEY_UNKNOWN = 8'h7F;

  // One word on the result channel.
  typedef struct packed {
    logic            kind;
    sces_pkg::byte_t ch;
    logic [2:0]      leds;
    logic            last;
  } out_word_t;

  // One scancode waiting to be sent; drain holds it back until the block is empty.
  typedef struct {
    sces_pkg::byte_t code;
    bit              drain;
  } key_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       key_valid = 1'b0;
  logic       key_ready;
  logic [7:0] scancode = 8'h00;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic       kind;
  logic [7:0] char_byte;
  logic [2:0] led_bits;
  logic       last;

  key_item_t       key_queue[$];
  out_word_t       expected_words[$];
  sces_pkg::byte_t seq_bytes[$];

  // Predicted keyboard state: held modifiers and the lock LEDs.
  logic [3:0] held_mods = '0;
  logic [2:0] lock_state = '0;

  int  keys_made = 0;
  bit  drain_next = 1'b0;
  int  keys_taken = 0;
  int  words_predicted = 0;
  int  words_checked = 0;
  int  led_updates = 0;
  int  char_runs = 0;
  int  mismatches = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  cycle_count = 0;
  logic calm;

  scancode_to_escape_sequence_unit dut (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .scancode  (scancode),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .kind      (kind),
    .char_byte (char_byte),
    .led_bits  (led_bits),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Neither side idles while the accepted count lies in the calm window.
  assign calm = keys_taken >= CALM_FROM && keys_taken < CALM_TO;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Plain and shifted glyph of a key, packed as {plain, shifted}; zero if the key has none.
  function automatic logic [15:0] glyph_pair(input logic [6:0] code);
    string digits = "1234567890";
    string digits_up = "!@#$%^&*()";
    string row_q = "qwertyuiop";
    string row_a = "asdfghjkl";
    string row_z = "zxcvbnm";
    if (code >= 2 && code <= 11) return {digits[code - 2], digits_up[code - 2]};
    if (code >= 16 && code <= 25)
      return {row_q[code - 16], sces_pkg::byte_t'(row_q[code - 16] - 8'd32)};
    if (code >= 30 && code <= 38)
      return {row_a[code - 30], sces_pkg::byte_t'(row_a[code - 30] - 8'd32)};
    if (code >= 44 && code <= 50)
      return {row_z[code - 44], sces_pkg::byte_t'(row_z[code - 44] - 8'd32)};
    case (code)
      7'd1:  return {sces_pkg::CH_ESC, sces_pkg::CH_ESC};
      7'd12: return {"-", "_"};
      7'd13: return {"=", "+"};
      7'd14: return {8'h08, 8'h08};
      7'd15: return {8'h09, 8'h09};
      7'd26: return {"[", "{"};
      7'd27: return {"]", "}"};
      7'd28: return {8'h0A, 8'h0A};
      7'd39: return {";", ":"};
      7'd40: return {8'h27, 8'h22};
      7'd41: return {8'h60, 8'h7E};
      7'd43: return {8'h5C, 8'h7C};
      7'd51: return {",", "<"};
      7'd52: return {".", ">"};
      7'd53: return {"/", "?"};
      7'd57: return {" ", " "};
      default: return 16'h0000;
    endcase
  endfunction

  // Cursor, editing and function keys: the number and final byte of the long form.
  // The arrows, home and end have number 1; F1 to F4 have 11 to 14.
  function automatic void nav_key(input logic [6:0] code, output logic [4:0] num,
                                  output sces_pkg::byte_t fin);
    num = 5'd0;
    fin = 8'h00;
    case (code)
      7'h48: {num, fin} = {5'd1, "A"};
      7'h50: {num, fin} = {5'd1, "B"};
      7'h4D: {num, fin} = {5'd1, "C"};
      7'h4B: {num, fin} = {5'd1, "D"};
      7'h47: {num, fin} = {5'd1, "H"};
      7'h4F: {num, fin} = {5'd1, "F"};
      7'h49: {num, fin} = {5'd5, "~"};
      7'h51: {num, fin} = {5'd6, "~"};
      7'h52: {num, fin} = {5'd2, "~"};
      7'h53: {num, fin} = {5'd3, "~"};
      7'h3B: {num, fin} = {5'd11, "~"};
      7'h3C: {num, fin} = {5'd12, "~"};
      7'h3D: {num, fin} = {5'd13, "~"};
      7'h3E: {num, fin} = {5'd14, "~"};
      7'h3F: {num, fin} = {5'd15, "~"};
      7'h40: {num, fin} = {5'd17, "~"};
      7'h41: {num, fin} = {5'd18, "~"};
      7'h42: {num, fin} = {5'd19, "~"};
      7'h43: {num, fin} = {5'd20, "~"};
      7'h44: {num, fin} = {5'd21, "~"};
      7'h57: {num, fin} = {5'd23, "~"};
      7'h58: {num, fin} = {5'd24, "~"};
      7'h37: {num, fin} = {5'd25, "~"};
      default: ;
    endcase
  endfunction

  function automatic void add_number(input int v);
    if (v >= 10) seq_bytes.push_back(sces_pkg::byte_t'(sces_pkg::CH_ZERO + v / 10));
    seq_bytes.push_back(sces_pkg::byte_t'(sces_pkg::CH_ZERO + v % 10));
  endfunction

  function automatic void push_word(input logic k, input sces_pkg::byte_t ch,
                                    input logic fin_word);
    expected_words.push_back('{k, ch, lock_state, fin_word});
    words_predicted++;
  endfunction

  // Updates the predicted keyboard state for one scancode and queues the words it causes.
  function automatic void translate_scancode(input sces_pkg::byte_t sc);
    logic            brk;
    logic [6:0]      code;
    logic [2:0]      flip;
    logic [3:0]      mod;
    logic [15:0]     pair;
    sces_pkg::byte_t lo;
    sces_pkg::byte_t ch;
    logic [4:0]      num;
    sces_pkg::byte_t fin;
    int              mnum;
    brk = sc[sces_pkg::BREAK_BIT];
    code = sc[6:0];
    seq_bytes.delete();
    if (sc == sces_pkg::SC_NULL || sc == sces_pkg::SC_ACK || sc == sces_pkg::SC_RESEND)
      return;

    // Lock keys toggle on make only; the whole raw byte is compared.
    flip = '0;
    if (sc == sces_pkg::SC_CAPS) flip[sces_pkg::CAPS_LOCK_BIT] = 1'b1;
    else if (sc == sces_pkg::SC_NUM) flip[sces_pkg::NUM_LOCK_BIT] = 1'b1;
    else if (sc == sces_pkg::SC_SCROLL) flip[sces_pkg::SCROLL_LOCK_BIT] = 1'b1;
    if (flip != '0) begin
      lock_state ^= flip;
      push_word(sces_pkg::KIND_LED, 8'h00, 1'b1);
      return;
    end

    mod = '0;
    case (code)
      sces_pkg::SC_CTRL:                      mod[sces_pkg::MOD_CTRL] = 1'b1;
      sces_pkg::SC_LSHIFT, sces_pkg::SC_RSHIFT: mod[sces_pkg::MOD_SHIFT] = 1'b1;
      sces_pkg::SC_ALT, sces_pkg::SC_ALTGR:     mod[sces_pkg::MOD_ALT] = 1'b1;
      sces_pkg::SC_LMETA, sces_pkg::SC_RMETA:   mod[sces_pkg::MOD_META] = 1'b1;
      default: ;
    endcase
    if (mod != '0) begin
      held_mods = brk ? (held_mods & ~mod) : (held_mods | mod);
      return;
    end
    if (brk) return;

    // Printable keys: shift picks the shifted glyph, caps lock raises letters only.
    // Ctrl, alt and meta leave the glyph alone.
    if (code < 7'd64) begin
      pair = glyph_pair(code);
      lo = pair[15:8];
      ch = (held_mods[sces_pkg::MOD_SHIFT] || (lock_state[sces_pkg::CAPS_LOCK_BIT]
            && lo >= sces_pkg::CH_LOWA && lo <= sces_pkg::CH_LOWZ)) ? pair[7:0] : lo;
      if (ch != 8'h00) begin
        push_word(sces_pkg::KIND_CHAR, ch, 1'b1);
        return;
      end
    end

    nav_key(code, num, fin);
    if (held_mods == '0 && (num == 5'd1 || (num >= 5'd11 && num <= 5'd14))) begin
      // Short forms with nothing held: ESC [ letter for cursor keys, ESC O P..S for F1-F4.
      seq_bytes.push_back(sces_pkg::CH_ESC);
      if (num == 5'd1) begin
        seq_bytes.push_back(sces_pkg::CH_LBRACK);
        seq_bytes.push_back(fin);
      end else begin
        seq_bytes.push_back(sces_pkg::CH_UPPERO);
        seq_bytes.push_back(sces_pkg::byte_t'("P" + num - 5'd11));
      end
    end else if (num != 5'd0) begin
      // Long form ESC [ n ; m final, the modifier part only when something is held.
      mnum = 1 + held_mods[sces_pkg::MOD_SHIFT] + 2 * held_mods[sces_pkg::MOD_ALT]
             + 4 * held_mods[sces_pkg::MOD_CTRL] + 8 * held_mods[sces_pkg::MOD_META];
      seq_bytes.push_back(sces_pkg::CH_ESC);
      seq_bytes.push_back(sces_pkg::CH_LBRACK);
      add_number(num);
      if (mnum != 1) begin
        seq_bytes.push_back(sces_pkg::CH_SEMI);
        add_number(mnum);
      end
      seq_bytes.push_back(fin);
    end else begin
      // Numpad minus, plus and five give a single byte; anything else is unknown.
      case (code)
        sces_pkg::SC_KP_MINUS: seq_bytes.push_back(sces_pkg::CH_MINUS);
        sces_pkg::SC_KP_PLUS:  seq_bytes.push_back(sces_pkg::CH_PLUS);
        sces_pkg::SC_KP_FIVE:  seq_bytes.push_back(sces_pkg::CH_FIVE);
        default: ;
      endcase
    end
    foreach (seq_bytes[i])
      push_word(sces_pkg::KIND_CHAR, seq_bytes[i], i == seq_bytes.size() - 1);
  endfunction

  function automatic void add_key(input sces_pkg::byte_t sc);
    key_queue.push_back('{sc, drain_next});
    drain_next = 1'b0;
    keys_made++;
  endfunction

  // Driver: predicts each scancode at the edge where it is accepted, then offers the
  // next one unless it idles or waits for the block to drain.
  always @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      scancode <= 8'h00;
      keys_taken <= 0;
      held_mods = '0;
      lock_state = '0;
      words_predicted = 0;
    end else begin
      if (key_valid && key_ready) begin
        translate_scancode(scancode);
        keys_taken <= keys_taken + 1;
      end
      if (!key_valid || key_ready) begin
        if (key_queue.size() != 0 && !(key_queue[0].drain && words_checked != words_predicted)
            && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          scancode <= key_queue[0].code;
          key_valid <= 1'b1;
          void'(key_queue.pop_front());
        end else begin
          key_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so that the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && keys_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: every accepted word is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    out_word_t want;
    if (rst) begin
      res_ready <= 1'b0;
      words_checked <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected: kind %0b byte %02h leds %03b",
                                    kind, char_byte, led_bits));
        end else begin
          want = expected_words.pop_front();
          words_checked <= words_checked + 1;
          if (kind !== want.kind)
            report_mismatch($sformatf("word %0d kind %0b, expected %0b",
                                      words_checked, kind, want.kind));
          if (char_byte !== want.ch)
            report_mismatch($sformatf("word %0d char_byte %02h, expected %02h",
                                      words_checked, char_byte, want.ch));
          if (led_bits !== want.leds)
            report_mismatch($sformatf("word %0d led_bits %03b, expected %03b",
                                      words_checked, led_bits, want.leds));
          if (last !== want.last)
            report_mismatch($sformatf("word %0d last %0b, expected %0b",
                                      words_checked, last, want.last));
          if (want.last && want.kind == sces_pkg::KIND_LED) led_updates++;
          else if (want.last) char_runs++;
        end
      end
      res_ready <= hold_left == 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               expected_words.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int              pick;
    int              nkeys;
    sces_pkg::byte_t k;
    logic [3:0]      mods;
    sces_pkg::byte_t mod_make[4];
    bit              drain_done;
    drain_done = 1'b0;

    // Directed opening: fillers, lock keys and caps on letters and digits, all four
    // modifiers held on the longest sequence, a short form, the numpad specials,
    // an unknown make and a break of an unknown key.
    add_key(sces_pkg::SC_NULL);
    add_key(sces_pkg::SC_ACK);
    add_key(sces_pkg::SC_RESEND);
    add_key(sces_pkg::SC_CAPS);
    add_key(KEY_A);
    add_key(KEY_ONE);
    add_key(sces_pkg::SC_CAPS | BRK_FLAG);
    add_key(sces_pkg::SC_NUM);
    add_key(sces_pkg::SC_SCROLL);
    add_key({1'b0, sces_pkg::SC_LSHIFT});
    add_key({1'b0, sces_pkg::SC_CTRL});
    add_key({1'b0, sces_pkg::SC_ALT});
    add_key({1'b0, sces_pkg::SC_LMETA});
    add_key(KEY_F12);
    add_key(KEY_A);
    add_key({1'b0, sces_pkg::SC_KP_MINUS});
    add_key({1'b1, sces_pkg::SC_CTRL});
    add_key({1'b1, sces_pkg::SC_ALT});
    add_key({1'b1, sces_pkg::SC_LMETA});
    add_key({1'b1, sces_pkg::SC_LSHIFT});
    add_key(KEY_F1);
    add_key({1'b0, sces_pkg::SC_KP_PLUS});
    add_key({1'b0, sces_pkg::SC_KP_FIVE});
    add_key(KEY_UNKNOWN);
    add_key(KEY_UNKNOWN | BRK_FLAG);
    add_key(sces_pkg::SC_CAPS);

    // Random part: mostly well-formed key strokes, some noise.
    while (keys_made < KEY_COUNT) begin
      if (!drain_done && keys_made >= DRAIN_AT) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        // Printable key, usually followed by its release.
        k = sces_pkg::byte_t'($urandom_range(1, 57));
        add_key(k);
        if ($urandom_range(0, 9) < 6) add_key(k | BRK_FLAG);
      end else if (pick < 55) begin
        // Navigation or function keys inside a random set of held modifiers.
        mods = 4'($urandom_range(0, 15));
        mod_make[sces_pkg::MOD_CTRL] = {1'b0, sces_pkg::SC_CTRL};
        mod_make[sces_pkg::MOD_SHIFT] =
          {1'b0, $urandom_range(0, 1) ? sces_pkg::SC_LSHIFT : sces_pkg::SC_RSHIFT};
        mod_make[sces_pkg::MOD_ALT] =
          {1'b0, $urandom_range(0, 1) ? sces_pkg::SC_ALT : sces_pkg::SC_ALTGR};
        mod_make[sces_pkg::MOD_META] =
          {1'b0, $urandom_range(0, 1) ? sces_pkg::SC_LMETA : sces_pkg::SC_RMETA};
        for (int i = 0; i < 4; i++) if (mods[i]) add_key(mod_make[i]);
        nkeys = $urandom_range(1, 3);
        for (int i = 0; i < nkeys; i++)
          add_key(sces_pkg::byte_t'($urandom_range(8'h37, 8'h58)));
        for (int i = 0; i < 4; i++) if (mods[i]) add_key(mod_make[i] | BRK_FLAG);
      end else if (pick < 63) begin
        case ($urandom_range(0, 2))
          0: k = sces_pkg::SC_CAPS;
          1: k = sces_pkg::SC_NUM;
          default: k = sces_pkg::SC_SCROLL;
        endcase
        add_key(k);
        if ($urandom_range(0, 1)) add_key(k | BRK_FLAG);
      end else if (pick < 73) begin
        // A lone modifier make or break leaves keys held for the strokes that follow.
        case ($urandom_range(0, 6))
          0: k = {1'b0, sces_pkg::SC_CTRL};
          1: k = {1'b0, sces_pkg::SC_LSHIFT};
          2: k = {1'b0, sces_pkg::SC_RSHIFT};
          3: k = {1'b0, sces_pkg::SC_ALT};
          4: k = {1'b0, sces_pkg::SC_ALTGR};
          5: k = {1'b0, sces_pkg::SC_LMETA};
          default: k = {1'b0, sces_pkg::SC_RMETA};
        endcase
        add_key($urandom_range(0, 1) ? k : (k | BRK_FLAG));
      end else if (pick < 83) begin
        add_key(sces_pkg::byte_t'($urandom_range(8'h47, 8'h53)));
      end else if (pick < 93) begin
        add_key(sces_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 2))
          0: add_key(sces_pkg::SC_NULL);
          1: add_key(sces_pkg::SC_ACK);
          default: add_key(sces_pkg::SC_RESEND);
        endcase
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (key_queue.size() != 0 || key_valid || words_checked != words_predicted)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));

    $display("Sent %0d scancodes and checked %0d words in %0d cycles.", keys_taken,
             words_checked, cycle_count);
    $display("Covered %0d characters or escape sequences and %0d LED updates.", char_runs,
             led_updates);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- scancode_to_escape_sequence_unit.f -----
+incdir+rtl
rtl/sces_pkg.sv
rtl/sces_state_ram.sv
rtl/sces_decode.sv
rtl/sces_serializer.sv
rtl/scancode_to_escape_sequence_unit.sv
tb/sv/testbench.sv
